// ----- design/fbfla_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types and constants for the fixed-block free-list allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int DEF_NUM_BLOCKS   = 256;

  localparam int COUNT_W          = 9;
  localparam int BYTES_W          = 16;
  localparam int IN_IDX_W         = 8;
  localparam int OFFSET_W         = 24;
  localparam int STATUS_W         = 2;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 1;

  localparam int RESET_COUNT      = 256;
  localparam int RESET_BYTES      = 8;
  localparam int MIN_BLOCK_BYTES  = 8;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_idx_t;

endpackage
`default_nettype wire

// ----- design/fbfla_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_req_if
// Request channel: alloc / free items with valid-ready handshake.
// ----------------------------------------------------------------------------
interface fbfla_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [fbfla_pkg::IN_IDX_W-1:0]    block_index;

  modport source (output valid, output req_type, output block_index, input ready);
  modport sink   (input valid, input req_type, input block_index, output ready);
endinterface
`default_nettype wire

// ----- design/fbfla_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_rsp_if
// Result channel: one result item per request, valid-ready handshake.
// ----------------------------------------------------------------------------
interface fbfla_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              granted;
  logic [fbfla_pkg::IN_IDX_W-1:0]    alloc_index;
  logic [fbfla_pkg::OFFSET_W-1:0]    alloc_offset;
  logic [fbfla_pkg::STATUS_W-1:0]    status;
  logic [fbfla_pkg::COUNT_W-1:0]     free_blocks;

  modport source (output valid, output granted, output alloc_index, output alloc_offset,
                  output status, output free_blocks, input ready);
  modport sink   (input valid, input granted, input alloc_index, input alloc_offset,
                  input status, input free_blocks, output ready);
endinterface
`default_nettype wire

// ----- design/fixed_block_free_list_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// LIFO free-list allocator for a pool of fixed-size blocks.
// ----------------------------------------------------------------------------
// One request item is taken per clock while ready (no rebuild, no stalled
// result); its result is registered. The only loop is head -> link memory
// -> head, closed by keeping the link of the current head in a register
// (memory read data after an alloc, the old head after a free). After reset
// and every nonzero write of block_count the free list is rebuilt one entry
// per cycle, with the input not ready meanwhile. Blocks are handed out from
// the highest index down. Only frees of an out-of-range index, or frees with
// every block already free, are rejected; other double frees are not caught.
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = fbfla_pkg::DEF_NUM_BLOCKS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  fbfla_req_if.sink                               in_chan,
  fbfla_rsp_if.source                             out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [fbfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbfla_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CW    = fbfla_pkg::COUNT_W;
  localparam int RST_COUNT_I = (fbfla_pkg::RESET_COUNT > NUM_BLOCKS) ?
                               NUM_BLOCKS : fbfla_pkg::RESET_COUNT;
  localparam logic [CW-1:0]    RST_COUNT = CW'(RST_COUNT_I);
  localparam logic [IDX_W-1:0] RST_HEAD  = IDX_W'(RST_COUNT_I - 1);
  localparam logic [IDX_W-1:0] RST_LINK  = IDX_W'((RST_COUNT_I >= 2) ? RST_COUNT_I - 2 : 0);

  // link memory
  logic [IDX_W-1:0] link_mem [NUM_BLOCKS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] rd_data_r;

  // control state
  logic [CW-1:0]                     count_r, count_nxt;
  logic [fbfla_pkg::BYTES_W-1:0]     bytes_r, bytes_nxt;
  logic                              rebuilding_r, rebuilding_nxt;
  logic [CW-1:0]                     cursor_r, cursor_nxt;
  logic [IDX_W-1:0]                  head_r, head_nxt;
  logic [CW-1:0]                     free_total_r, free_total_nxt;
  logic                              link_sel_r, link_sel_nxt;
  logic [IDX_W-1:0]                  link_hold_r, link_hold_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // result payload
  logic                              granted_r, granted_nxt;
  logic [fbfla_pkg::IN_IDX_W-1:0]    aidx_r, aidx_nxt;
  logic [fbfla_pkg::OFFSET_W-1:0]    aoff_r, aoff_nxt;
  logic [fbfla_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [CW-1:0]                     fblk_r, fblk_nxt;

  logic                              accept;
  logic [IDX_W-1:0]                  head_link;
  logic [CW-1:0]                     cfg_count;
  logic [fbfla_pkg::BYTES_W-1:0]     eff_bytes;
  logic [fbfla_pkg::IN_IDX_W-1:0]    head8;
  logic [CW-1:0]                     req_idx9;

  assign in_chan.ready = !rebuilding_r && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  // link of the current head: memory data after an alloc, held value otherwise
  assign head_link = link_sel_r ? rd_data_r : link_hold_r;

  assign cfg_count = (cfg_wdata[CW-1:0] > CW'(NUM_BLOCKS)) && (NUM_BLOCKS < (1 << CW)) ?
                     CW'(NUM_BLOCKS) : cfg_wdata[CW-1:0];
  assign eff_bytes = (bytes_r < fbfla_pkg::BYTES_W'(fbfla_pkg::MIN_BLOCK_BYTES)) ?
                     fbfla_pkg::BYTES_W'(fbfla_pkg::MIN_BLOCK_BYTES) : bytes_r;
  assign head8     = fbfla_pkg::IN_IDX_W'(head_r);
  assign req_idx9  = CW'(in_chan.block_index);

  always_comb begin
    count_nxt      = count_r;
    bytes_nxt      = bytes_r;
    rebuilding_nxt = rebuilding_r;
    cursor_nxt     = cursor_r;
    head_nxt       = head_r;
    free_total_nxt = free_total_r;
    link_sel_nxt   = link_sel_r;
    link_hold_nxt  = link_hold_r;
    out_valid_nxt  = out_valid_r;
    granted_nxt    = granted_r;
    aidx_nxt       = aidx_r;
    aoff_nxt       = aoff_r;
    status_nxt     = status_r;
    fblk_nxt       = fblk_r;
    mem_we         = 1'b0;
    mem_waddr      = head_r;
    mem_wdata      = head_r;
    mem_re         = 1'b0;
    mem_raddr      = head_link;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (rebuilding_r) begin
      mem_we     = 1'b1;
      mem_waddr  = IDX_W'(cursor_r);
      mem_wdata  = (cursor_r == '0) ? '0 : IDX_W'(cursor_r - 1'b1);
      cursor_nxt = cursor_r + 1'b1;
      if (cursor_nxt == count_r) begin
        rebuilding_nxt = 1'b0;
      end
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      granted_nxt   = 1'b0;
      aidx_nxt      = '0;
      aoff_nxt      = '0;
      status_nxt    = fbfla_pkg::ST_OK;
      if (in_chan.req_type == fbfla_pkg::REQ_ALLOC) begin
        if (free_total_r == '0) begin
          status_nxt = fbfla_pkg::ST_EMPTY;
        end else begin
          granted_nxt    = 1'b1;
          aidx_nxt       = head8;
          aoff_nxt       = fbfla_pkg::OFFSET_W'(head_r) * fbfla_pkg::OFFSET_W'(eff_bytes);
          head_nxt       = head_link;
          free_total_nxt = free_total_r - 1'b1;
          mem_re         = 1'b1;
          link_sel_nxt   = 1'b1;
        end
      end else begin
        if ((req_idx9 >= count_r) || (free_total_r >= count_r)) begin
          status_nxt = fbfla_pkg::ST_BAD_FREE;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = IDX_W'(in_chan.block_index);
          mem_wdata      = head_r;
          head_nxt       = IDX_W'(in_chan.block_index);
          link_hold_nxt  = head_r;
          link_sel_nxt   = 1'b0;
          free_total_nxt = free_total_r + 1'b1;
        end
      end
      fblk_nxt = free_total_nxt;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        fbfla_pkg::CFG_BLOCK_COUNT: begin
          count_nxt      = cfg_count;
          rebuilding_nxt = (cfg_count != '0);
          cursor_nxt     = '0;
          free_total_nxt = cfg_count;
          head_nxt       = (cfg_count == '0) ? '0 : IDX_W'(cfg_count - 1'b1);
          link_hold_nxt  = (cfg_count < CW'(2)) ? '0 : IDX_W'(cfg_count - CW'(2));
          link_sel_nxt   = 1'b0;
        end
        fbfla_pkg::CFG_BLOCK_BYTES: begin
          bytes_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= RST_COUNT;
      bytes_r      <= fbfla_pkg::BYTES_W'(fbfla_pkg::RESET_BYTES);
      rebuilding_r <= 1'b1;
      cursor_r     <= '0;
      head_r       <= RST_HEAD;
      free_total_r <= RST_COUNT;
      link_sel_r   <= 1'b0;
      link_hold_r  <= RST_LINK;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      bytes_r      <= bytes_nxt;
      rebuilding_r <= rebuilding_nxt;
      cursor_r     <= cursor_nxt;
      head_r       <= head_nxt;
      free_total_r <= free_total_nxt;
      link_sel_r   <= link_sel_nxt;
      link_hold_r  <= link_hold_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    aidx_r    <= aidx_nxt;
    aoff_r    <= aoff_nxt;
    status_r  <= status_nxt;
    fblk_r    <= fblk_nxt;
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= link_mem[mem_raddr];
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.granted      = granted_r;
  assign out_chan.alloc_index  = aidx_r;
  assign out_chan.alloc_offset = aoff_r;
  assign out_chan.status       = status_r;
  assign out_chan.free_blocks  = fblk_r;

endmodule
`default_nettype wire

// ----- design/fbfla_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbfla_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
module fbfla_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic                               out_granted,
  input wire logic [fbfla_pkg::IN_IDX_W-1:0]     out_alloc_index,
  input wire logic [fbfla_pkg::OFFSET_W-1:0]     out_alloc_offset,
  input wire logic [fbfla_pkg::STATUS_W-1:0]     out_status,
  input wire logic [fbfla_pkg::COUNT_W-1:0]      out_free_blocks
);

  // a grant always reports ok, a refusal never carries a block
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (out_status == fbfla_pkg::ST_OK))
    else $error("granted item with non-ok status");

  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_alloc_index == '0 && out_alloc_offset == '0))
    else $error("refused item carries index or offset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == fbfla_pkg::ST_OK || out_status == fbfla_pkg::ST_EMPTY ||
                   out_status == fbfla_pkg::ST_BAD_FREE))
    else $error("undefined status code");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_blocks <= fbfla_pkg::COUNT_W'(fbfla_pkg::RESET_COUNT)))
    else $error("free count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_alloc_offset) &&
                                   $stable(out_free_blocks)))
    else $error("stalled result item changed");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_granted      (out_chan.granted),
  .out_alloc_index  (out_chan.alloc_index),
  .out_alloc_offset (out_chan.alloc_offset),
  .out_status       (out_chan.status),
  .out_free_blocks  (out_chan.free_blocks)
);
`default_nettype wire
